### src/irac_pkg.sv
// Shared types, timing constants and frame tables for the AC infrared symbol generator.
// Used by irac_symbol_decode, irac_msg_state and ir_ac_frame_symbol_generator.
package irac_pkg;

  // One result beat before packing onto the output bus
  typedef struct packed {
    logic [14:0] duration;
    logic        level;
    logic        last;
    logic        valid_res;
  } irac_res_t;

  // Input opcodes (carried in in_tuser)
  localparam logic OP_START = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Symbol durations in microseconds
  localparam logic [14:0] HDR_MARK_US   = 15'd3500;
  localparam logic [14:0] HDR_SPACE_US  = 15'd1750;
  localparam logic [14:0] BIT_MARK_US   = 15'd430;
  localparam logic [14:0] ONE_SPACE_US  = 15'd1300;
  localparam logic [14:0] ZERO_SPACE_US = 15'd430;
  localparam logic [14:0] GAP_SPACE_US  = 15'd25000;

  // Symbol positions within the 440-symbol message
  localparam logic [8:0] POS_HDR1_MARK  = 9'd0;
  localparam logic [8:0] POS_HDR1_SPACE = 9'd1;
  localparam logic [8:0] POS_F1_FIRST   = 9'd2;
  localparam logic [8:0] POS_STOP1      = 9'd130;
  localparam logic [8:0] POS_GAP        = 9'd131;
  localparam logic [8:0] POS_HDR2_MARK  = 9'd132;
  localparam logic [8:0] POS_HDR2_SPACE = 9'd133;
  localparam logic [8:0] POS_F2_FIRST   = 9'd134;
  localparam logic [8:0] POS_STOP2      = 9'd438;

  // Sum of the fixed bytes of the control frame, modulo 256
  localparam logic [7:0] CTRL_FIXED_SUM = 8'h5A;

  // Map the mode selector onto the mode nibble; unknown modes fall back to cool
  function automatic logic [3:0] mode_code_of(input logic [2:0] sel);
    logic [3:0] code;
    case (sel)
      3'd0:    code = 4'h0;
      3'd1:    code = 4'h3;
      3'd2:    code = 4'h4;
      3'd3:    code = 4'h6;
      3'd4:    code = 4'h2;
      default: code = 4'h3;
    endcase
    return code;
  endfunction

  // Fixed first frame
  function automatic logic [7:0] first_frame_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h11;
      3'd1:    b = 8'hDA;
      3'd2:    b = 8'h27;
      3'd3:    b = 8'h00;
      3'd4:    b = 8'hC5;
      3'd5:    b = 8'h00;
      3'd6:    b = 8'h00;
      default: b = 8'hD7;
    endcase
    return b;
  endfunction

  // Control frame byte, with the latched settings spliced in
  function automatic logic [7:0] ctrl_frame_byte(input logic [4:0] idx,
                                                 input logic [7:0] b5,
                                                 input logic [7:0] b6,
                                                 input logic [7:0] b18);
    logic [7:0] b;
    case (idx)
      5'd0:    b = 8'h11;
      5'd1:    b = 8'hDA;
      5'd2:    b = 8'h27;
      5'd4:    b = 8'h42;
      5'd5:    b = b5;
      5'd6:    b = b6;
      5'd17:   b = 8'h06;
      5'd18:   b = b18;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### src/irac_symbol_decode.sv
// Position decoder: turns a message symbol position and the latched settings
// into one mark/space symbol. Depends on irac_pkg.
module irac_symbol_decode (
  input  logic [8:0]          pos,
  input  logic                power_bit,
  input  logic [3:0]          mode_code,
  input  logic [7:0]          temp_byte,
  input  logic [7:0]          sum_byte,
  output irac_pkg::irac_res_t sym
);

  logic [8:0] q1_full;
  logic [8:0] q2_full;
  logic [7:0] f1_byte;
  logic [7:0] f2_byte;
  logic [7:0] b5;

  assign q1_full = pos - irac_pkg::POS_F1_FIRST;
  assign q2_full = pos - irac_pkg::POS_F2_FIRST;
  assign b5      = {mode_code, 3'b000, power_bit};

  // Pick the byte that carries the current bit, LSB first, 16 symbols per byte
  assign f1_byte = irac_pkg::first_frame_byte(q1_full[6:4]);
  assign f2_byte = irac_pkg::ctrl_frame_byte(q2_full[8:4], b5, temp_byte, sum_byte);

  // Classify the position and form the symbol
  always_comb begin
    sym           = '0;
    sym.valid_res = 1'b1;
    if (pos == irac_pkg::POS_HDR1_MARK || pos == irac_pkg::POS_HDR2_MARK) begin
      sym.duration = irac_pkg::HDR_MARK_US;
      sym.level    = 1'b1;
    end else if (pos == irac_pkg::POS_HDR1_SPACE || pos == irac_pkg::POS_HDR2_SPACE) begin
      sym.duration = irac_pkg::HDR_SPACE_US;
    end else if (pos >= irac_pkg::POS_F1_FIRST && pos < irac_pkg::POS_STOP1) begin
      if (!q1_full[0]) begin
        sym.duration = irac_pkg::BIT_MARK_US;
        sym.level    = 1'b1;
      end else begin
        sym.duration = f1_byte[q1_full[3:1]] ? irac_pkg::ONE_SPACE_US
                                             : irac_pkg::ZERO_SPACE_US;
      end
    end else if (pos == irac_pkg::POS_STOP1 || pos == irac_pkg::POS_STOP2) begin
      sym.duration = irac_pkg::BIT_MARK_US;
      sym.level    = 1'b1;
    end else if (pos == irac_pkg::POS_GAP) begin
      sym.duration = irac_pkg::GAP_SPACE_US;
    end else if (pos >= irac_pkg::POS_F2_FIRST && pos < irac_pkg::POS_STOP2) begin
      if (!q2_full[0]) begin
        sym.duration = irac_pkg::BIT_MARK_US;
        sym.level    = 1'b1;
      end else begin
        sym.duration = f2_byte[q2_full[3:1]] ? irac_pkg::ONE_SPACE_US
                                             : irac_pkg::ZERO_SPACE_US;
      end
    end else begin
      // Zero-length pad closes the message
      sym.last = 1'b1;
    end
  end

endmodule

### src/irac_msg_state.sv
// Message state: latched settings, checksum, symbol position and busy flag,
// plus the result for each beat. Depends on irac_pkg and irac_symbol_decode.
module irac_msg_state (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic                op,
  input  logic                power_on,
  input  logic [2:0]          mode_select,
  input  logic [6:0]          temperature,
  output irac_pkg::irac_res_t res
);

  logic       power_bit_r, power_bit_nxt;
  logic [3:0] mode_code_r, mode_code_nxt;
  logic [7:0] temp_byte_r, temp_byte_nxt;
  logic [7:0] sum_byte_r, sum_byte_nxt;
  logic [8:0] pos_r, pos_nxt;
  logic       busy_r, busy_nxt;

  logic [3:0]          new_mode;
  logic [7:0]          new_temp;
  irac_pkg::irac_res_t sym;

  assign new_mode = irac_pkg::mode_code_of(mode_select);
  assign new_temp = {temperature, 1'b0};

  irac_symbol_decode u_decode (
    .pos       (pos_r),
    .power_bit (power_bit_r),
    .mode_code (mode_code_r),
    .temp_byte (temp_byte_r),
    .sum_byte  (sum_byte_r),
    .sym       (sym)
  );

  // Start latches settings; a fetch during a message hands out a symbol and advances
  always_comb begin
    power_bit_nxt = power_bit_r;
    mode_code_nxt = mode_code_r;
    temp_byte_nxt = temp_byte_r;
    sum_byte_nxt  = sum_byte_r;
    pos_nxt       = pos_r;
    busy_nxt      = busy_r;
    res           = '0;
    if (op == irac_pkg::OP_START) begin
      power_bit_nxt = power_on;
      mode_code_nxt = new_mode;
      temp_byte_nxt = new_temp;
      sum_byte_nxt  = irac_pkg::CTRL_FIXED_SUM + {new_mode, 3'b000, power_on} + new_temp;
      pos_nxt       = '0;
      busy_nxt      = 1'b1;
    end else if (busy_r) begin
      res = sym;
      if (sym.last) begin
        busy_nxt = 1'b0;
        pos_nxt  = '0;
      end else begin
        pos_nxt = pos_r + 9'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_bit_r <= 1'b0;
      mode_code_r <= '0;
      temp_byte_r <= '0;
      sum_byte_r  <= '0;
      pos_r       <= '0;
      busy_r      <= 1'b0;
    end else if (step_en) begin
      power_bit_r <= power_bit_nxt;
      mode_code_r <= mode_code_nxt;
      temp_byte_r <= temp_byte_nxt;
      sum_byte_r  <= sum_byte_nxt;
      pos_r       <= pos_nxt;
      busy_r      <= busy_nxt;
    end
  end

endmodule

### src/ir_ac_frame_symbol_generator.sv
// Top level of the AC infrared symbol generator: input register, message state
// and output register. Depends on irac_pkg and irac_msg_state.

// Every input beat gives exactly one output beat. A start beat (in_tuser = 0)
// latches power, mode and temperature, restarts the message and returns an
// empty beat with out_tuser = 0. Each fetch beat (in_tuser = 1) returns the next
// mark/space symbol of the 440-symbol message (out_tuser = 1), with out_tlast on
// the closing zero-length pad; a fetch with no message in progress returns an
// empty beat. A beat passes through an input register and an output register:
// it is held in the input register once accepted, and its result is loaded into
// the output register when the input register advances, which waits while the
// output side stalls. One beat is accepted per cycle as long as the output side
// keeps taking beats; the combinational symbol decode and state update set that figure.
module ir_ac_frame_symbol_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [0] power_on, [3:1] mode_select, [10:4] temperature
  input  logic [0:0]  in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [14:0] duration, [15] level
  output logic [0:0]  out_tuser,  // [0] valid_res
  output logic        out_tlast
);

  logic       s1_valid_r;
  logic       s1_op_r;
  logic       s1_power_r;
  logic [2:0] s1_mode_r;
  logic [6:0] s1_temp_r;
  logic       s1_fire;
  logic       in_fire;

  logic                out_valid_r;
  irac_pkg::irac_res_t out_res_r;
  irac_pkg::irac_res_t res;

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r    <= in_tuser[0];
      s1_power_r <= in_tdata[0];
      s1_mode_r  <= in_tdata[3:1];
      s1_temp_r  <= in_tdata[10:4];
    end
  end

  irac_msg_state u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (s1_fire),
    .op          (s1_op_r),
    .power_on    (s1_power_r),
    .mode_select (s1_mode_r),
    .temperature (s1_temp_r),
    .res         (res)
  );

  // Output register: load on advance, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {out_res_r.level, out_res_r.duration};
  assign out_tuser[0] = out_res_r.valid_res;
  assign out_tlast    = out_res_r.last;

endmodule

### tb/ir_ac_frame_symbol_generator_tb.sv
// Self-checking testbench for ir_ac_frame_symbol_generator: drives start and fetch beats,
// predicts every symbol of the infrared message and compares each output beat.
// Depends on irac_pkg and the RTL under src/.
`timescale 1ns / 100ps

module ir_ac_frame_symbol_generator_tb;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned RANDOM_BEATS  = 400;
  localparam int unsigned MSG_SYMBOLS   = 440;
  localparam int unsigned LONG_HOLD     = 300;
  // First frame, byte 0 in the lowest bits
  localparam logic [63:0] FIXED_FRAME   = 64'hD7_00_00_C5_00_27_DA_11;
  // Mode nibble per selector value, selector 0 in the lowest nibble
  localparam logic [31:0] MODE_NIBBLES  = 32'h3332_6430;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [0] power_on, [3:1] mode_select, [10:4] temperature
  logic [0:0]  in_tuser;   // [0] op
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [14:0] duration, [15] level
  logic [0:0]  out_tuser;  // [0] valid_res
  logic        out_tlast;

  // Expected symbols, oldest first
  irac_pkg::irac_res_t symbol_q[$];
  int unsigned error_count;
  int unsigned beats_sent;
  logic        tx_idle_en;
  logic        rx_idle_en;
  int unsigned rx_hold_cycles;

  // Predicted message state
  logic        msg_power;
  logic [3:0]  msg_mode;
  logic [7:0]  msg_temp;
  logic [151:0] ctrl_frame_bits;  // control frame, byte 0 in the lowest bits
  logic [8:0]  msg_pos;
  logic        msg_busy;

  ir_ac_frame_symbol_generator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Work out the symbol that one accepted beat yields and advance the message state
  task automatic predict_symbol(input logic op, input logic pwr, input logic [2:0] mode,
                                input logic [6:0] temp, output irac_pkg::irac_res_t sym);
    logic [7:0] sum;
    logic [8:0] q;
    logic       in_body;
    logic       bit_val;
    sym     = '0;
    in_body = 1'b0;
    bit_val = 1'b0;
    q       = '0;
    if (op == irac_pkg::OP_START) begin
      msg_power = pwr;
      msg_mode  = MODE_NIBBLES[{mode, 2'b00} +: 4];
      msg_temp  = {temp, 1'b0};
      ctrl_frame_bits = '0;
      ctrl_frame_bits[0 +: 8]   = 8'h11;
      ctrl_frame_bits[8 +: 8]   = 8'hDA;
      ctrl_frame_bits[16 +: 8]  = 8'h27;
      ctrl_frame_bits[32 +: 8]  = 8'h42;
      ctrl_frame_bits[40 +: 8]  = {msg_mode, 3'b000, msg_power};
      ctrl_frame_bits[48 +: 8]  = msg_temp;
      ctrl_frame_bits[136 +: 8] = 8'h06;
      sum = '0;
      for (int k = 0; k < 18; k++) sum += ctrl_frame_bits[k*8 +: 8];
      ctrl_frame_bits[144 +: 8] = sum;
      msg_pos  = '0;
      msg_busy = 1'b1;
    end else if (msg_busy) begin
      sym.valid_res = 1'b1;
      if (msg_pos == irac_pkg::POS_HDR1_MARK || msg_pos == irac_pkg::POS_HDR2_MARK) begin
        sym.duration = irac_pkg::HDR_MARK_US;
        sym.level    = 1'b1;
      end else if (msg_pos == irac_pkg::POS_HDR1_SPACE ||
                   msg_pos == irac_pkg::POS_HDR2_SPACE) begin
        sym.duration = irac_pkg::HDR_SPACE_US;
      end else if (msg_pos >= irac_pkg::POS_F1_FIRST && msg_pos < irac_pkg::POS_STOP1) begin
        q       = msg_pos - irac_pkg::POS_F1_FIRST;
        in_body = 1'b1;
        bit_val = FIXED_FRAME[q[8:1]];
      end else if (msg_pos == irac_pkg::POS_STOP1 || msg_pos == irac_pkg::POS_STOP2) begin
        sym.duration = irac_pkg::BIT_MARK_US;
        sym.level    = 1'b1;
      end else if (msg_pos == irac_pkg::POS_GAP) begin
        sym.duration = irac_pkg::GAP_SPACE_US;
      end else if (msg_pos >= irac_pkg::POS_F2_FIRST && msg_pos < irac_pkg::POS_STOP2) begin
        q       = msg_pos - irac_pkg::POS_F2_FIRST;
        in_body = 1'b1;
        bit_val = ctrl_frame_bits[q[8:1]];
      end else begin
        sym.last = 1'b1;
      end
      // Even body symbols are bit marks, odd ones carry the bit in the space length
      if (in_body) begin
        if (!q[0]) begin
          sym.duration = irac_pkg::BIT_MARK_US;
          sym.level    = 1'b1;
        end else begin
          sym.duration = bit_val ? irac_pkg::ONE_SPACE_US : irac_pkg::ZERO_SPACE_US;
        end
      end
      if (sym.last) begin
        msg_busy = 1'b0;
        msg_pos  = '0;
      end else begin
        msg_pos = msg_pos + 9'd1;
      end
    end
  endtask

  // Offer one beat after a random gap, wait for the handshake and queue its symbol
  task automatic send_beat(input logic op, input logic pwr, input logic [2:0] mode,
                           input logic [6:0] temp);
    int unsigned         gap;
    irac_pkg::irac_res_t sym;
    gap = tx_idle_en ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, temp, mode, pwr};
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_symbol(op, pwr, mode, temp, sym);
    symbol_q.push_back(sym);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_start(input logic pwr, input logic [2:0] mode, input logic [6:0] temp);
    send_beat(irac_pkg::OP_START, pwr, mode, temp);
  endtask

  // Fetch beats carry random settings, which the block must ignore
  task automatic send_fetch(input int unsigned count);
    repeat (count)
      send_beat(irac_pkg::OP_FETCH, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                7'($urandom_range(0, 127)));
  endtask

  task automatic send_random_start();
    send_start(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
               7'($urandom_range(0, 127)));
  endtask

  // Hold the input side quiet until every queued symbol has come out
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (symbol_q.size() != 0);
  endtask

  // Fetches before any start return empty beats
  task automatic test_idle_fetch();
    send_fetch(2);
  endtask

  // Extreme settings, then the first symbols of each message
  task automatic test_setting_extremes();
    send_start(1'b1, 3'd7, 7'd127);
    send_fetch(3);
    send_start(1'b0, 3'd0, 7'd0);
    send_fetch(3);
  endtask

  // Remaining mode selectors, each start abandoning the previous message
  task automatic test_every_mode();
    for (int m = 1; m <= 6; m++) send_start(m[0], 3'(m), 7'(m * 21));
    send_fetch(2);
    send_start(1'b1, 3'd2, 7'd85);
    send_fetch(2);
  endtask

  // One whole message plus fetches past its end
  task automatic test_full_message();
    send_random_start();
    send_fetch(MSG_SYMBOLS + 2);
  endtask

  // Stall the output side for a long stretch while the input keeps offering beats
  task automatic test_backpressure();
    wait_drain();
    tx_idle_en     = 1'b0;
    rx_hold_cycles = LONG_HOLD;
    send_random_start();
    send_fetch(60);
    wait_drain();
    tx_idle_en = 1'b1;
  endtask

  // Mostly complete or abandoned messages with random settings, some loose beats
  task automatic test_random_messages();
    int unsigned first_beat;
    int unsigned kind;
    first_beat = beats_sent;
    while (beats_sent - first_beat < RANDOM_BEATS) begin
      kind       = $urandom_range(0, 9);
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      if (kind <= 4) begin
        send_random_start();
        send_fetch(MSG_SYMBOLS + $urandom_range(0, 3));
      end else if (kind <= 7) begin
        send_random_start();
        send_fetch($urandom_range(1, 300));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1) != 0) send_fetch(1);
          else send_random_start();
        end
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Output side: random stall before each beat, plus any long hold that is requested
  initial begin : drive_out_ready
    int unsigned stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall          = (rx_idle_en ? $urandom_range(0, 8) : 0) + rx_hold_cycles;
      rx_hold_cycles = 0;
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      error_count++;
    end
  endtask

  // Compare each accepted output beat with the oldest expected symbol
  always @(posedge clk) begin : check_symbols
    irac_pkg::irac_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (symbol_q.size() == 0) begin
        $display("%0t ns: unexpected beat, expected none, actual duration %0d level %0b",
                 $time, out_tdata[14:0], out_tdata[15]);
        $display("%0t ns: unexpected beat, actual last %0b valid_res %0b",
                 $time, out_tlast, out_tuser[0]);
        error_count++;
      end else begin
        want = symbol_q.pop_front();
        check_field("duration", 32'(want.duration), 32'(out_tdata[14:0]));
        check_field("level", 32'(want.level), 32'(out_tdata[15]));
        check_field("last", 32'(want.last), 32'(out_tlast));
        check_field("valid_res", 32'(want.valid_res), 32'(out_tuser[0]));
      end
    end
  end

  // Abort a hung run
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("ir_ac_frame_symbol_generator regression: fail");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = irac_pkg::OP_START;
    error_count    = 0;
    beats_sent     = 0;
    tx_idle_en     = 1'b1;
    rx_idle_en     = 1'b1;
    rx_hold_cycles = 0;
    msg_power      = 1'b0;
    msg_mode       = '0;
    msg_temp       = '0;
    ctrl_frame_bits = '0;
    msg_pos        = '0;
    msg_busy       = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_idle_fetch();
    test_setting_extremes();
    test_every_mode();
    test_full_message();
    test_backpressure();
    test_random_messages();

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("ir_ac_frame_symbol_generator regression: pass");
    end else begin
      $display("ir_ac_frame_symbol_generator regression: fail");
    end
    $finish;
  end

endmodule

### files.f
src/irac_pkg.sv
src/irac_symbol_decode.sv
src/irac_msg_state.sv
src/ir_ac_frame_symbol_generator.sv
tb/ir_ac_frame_symbol_generator_tb.sv
